/* rtl/core/fcf_pkg.sv */
`default_nettype none

package fcf_pkg;

  // Filter shape.
  localparam int TAPS        = 55;
  localparam int BLOCK_DELAY = 128;

  // Field widths.
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int TAP_IDX_W = 7;
  localparam int FRAC_BITS = 15;

  // Products are full precision; the sum grows by the log of the tap count.
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);

  // The first cell picks up each sample one item before it is used, so the
  // sample memory only has to cover one less than the block delay.
  localparam int DELAY_DEPTH = BLOCK_DELAY - 1;
  localparam int DPTR_W      = $clog2(DELAY_DEPTH);
  localparam int FILL_W      = $clog2(DELAY_DEPTH + 1);

  // Item operation codes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [TAP_IDX_W-1:0]       tap_idx_t;

  // One item as it travels down the cell chain.
  typedef struct packed {
    logic     valid;
    logic     is_load;
    tap_idx_t tap_index;
    coef_t    tap_value;
  } tok_t;

endpackage

`default_nettype wire

/* rtl/core/fcf_if.sv */
`default_nettype none

interface fcf_item_if;
  import fcf_pkg::*;

  logic     valid;
  logic     ready;
  logic     op;
  sample_t  sample_in;
  tap_idx_t tap_index;
  coef_t    tap_value;

  modport source (output valid, op, sample_in, tap_index, tap_value, input ready);
  modport sink   (input valid, op, sample_in, tap_index, tap_value, output ready);
endinterface

interface fcf_result_if;
  import fcf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/fcf_delay_line.sv */
`default_nettype none

module fcf_delay_line (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic             accept,
  input  wire logic             op,
  input  wire fcf_pkg::sample_t  sample_in,
  input  wire fcf_pkg::tap_idx_t tap_index,
  input  wire fcf_pkg::coef_t    tap_value,
  output fcf_pkg::tok_t          tok,
  output fcf_pkg::sample_t       x_out
);
  import fcf_pkg::*;

  sample_t             mem [DELAY_DEPTH];
  logic [DPTR_W-1:0]   wr_ptr;
  logic [FILL_W-1:0]   fill;
  sample_t             rd_data;
  logic                rd_zero;
  logic                push;

  assign push = accept && (op == OP_SAMPLE);

  // Until the memory has been filled once, the slot under the pointer was
  // never written and stands for a zero history sample.
  assign x_out = rd_zero ? '0 : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
      wr_ptr    <= '0;
      fill      <= '0;
      rd_zero   <= 1'b1;
    end else if (advance) begin
      tok.valid     <= accept;
      tok.is_load   <= (op == OP_LOAD);
      tok.tap_index <= tap_index;
      tok.tap_value <= tap_value;
      if (push) begin
        rd_zero <= (fill != FILL_W'(DELAY_DEPTH));
        if (fill != FILL_W'(DELAY_DEPTH)) begin
          fill <= fill + 1'b1;
        end
        if (wr_ptr == DPTR_W'(DELAY_DEPTH - 1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + 1'b1;
        end
      end
    end
  end

  // Read before write at the same slot returns the sample pushed one full
  // lap ago.
  always_ff @(posedge clk) begin
    if (push) begin
      rd_data     <= mem[wr_ptr];
      mem[wr_ptr] <= sample_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fcf_cell.sv */
`default_nettype none

module fcf_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire fcf_pkg::tap_idx_t cell_id,
  input  wire fcf_pkg::tok_t     tok_in,
  input  wire fcf_pkg::acc_t     acc_in,
  input  wire fcf_pkg::sample_t  x_in,
  output fcf_pkg::tok_t          tok_out,
  output fcf_pkg::acc_t          acc_out,
  output fcf_pkg::sample_t       x_out
);
  import fcf_pkg::*;

  coef_t   coef;
  sample_t x_hold;
  prod_t   prod;
  acc_t    acc_next;

  assign prod     = coef * x_hold;
  assign acc_next = acc_in + ACC_W'(prod);

  // A sample transaction uses the held sample, then the history moves one
  // place along the chain as a wave that travels with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      coef          <= '0;
      x_hold        <= '0;
    end else if (advance) begin
      tok_out <= tok_in;
      if (tok_in.valid && tok_in.is_load && (tok_in.tap_index == cell_id)) begin
        coef <= tok_in.tap_value;
      end
      if (tok_in.valid && !tok_in.is_load) begin
        x_hold <= x_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      acc_out <= acc_next;
      x_out   <= x_hold;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fcf_out_stage.sv */
`default_nettype none

module fcf_out_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fcf_pkg::tok_t  tok_in,
  input  wire fcf_pkg::acc_t  acc_in,
  output logic               advance,
  fcf_result_if.source       result
);
  import fcf_pkg::*;

  localparam acc_t BIAS   = acc_t'((2 ** FRAC_BITS) - 1);
  localparam acc_t SAT_HI = acc_t'((2 ** (SAMPLE_W - 1)) - 1);
  localparam acc_t SAT_LO = acc_t'(-(2 ** (SAMPLE_W - 1)));

  // Divide by the fraction scale rounding toward zero, then clamp.
  function automatic sample_t scale_sat(acc_t a);
    acc_t q;
    q = (a[ACC_W-1] ? (a + BIAS) : a) >>> FRAC_BITS;
    if (q > SAT_HI) begin
      return sample_t'(SAT_HI);
    end else if (q < SAT_LO) begin
      return sample_t'(SAT_LO);
    end
    return sample_t'(q);
  endfunction

  assign advance = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= tok_in.valid && !tok_in.is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok_in.valid && !tok_in.is_load) begin
      result.sample_out <= scale_sat(acc_in);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fast_convolution_fir_filter_core.sv */
`default_nettype none

// Channel   Role    Payload                                  Transaction
// --------  ------  ---------------------------------------  -----------------------------
// item_ch   sink    op, sample_in, tap_index, tap_value      one sample or one tap load
// result_ch source  sample_out                               one filtered sample
//
// One item is taken every clock cycle while the result register is free or
// being emptied. The result of a sample transaction passes through the delay
// line's item register, the TAPS cells and the result register; a tap load
// produces nothing. While the chain advances, the partial sum moves one cell per cycle.
// Reset is synchronous and clears all taps and the whole history; no clearing
// pass is needed. When result_ch stalls, the entire chain holds in place.

module fast_convolution_fir_filter_core (
  input  wire logic     clk,
  input  wire logic     rst,
  fcf_item_if.sink      item_ch,
  fcf_result_if.source  result_ch
);
  import fcf_pkg::*;

  // The chain advances as one: every register in the delay line, the cells
  // and the output stage moves together, so no item can overtake another.
  logic    advance;
  logic    accept;

  // Links between neighbors. Index 0 feeds the first cell; index TAPS is the
  // output of the last one.
  tok_t    tok_c [TAPS+1];
  acc_t    acc_c [TAPS+1];
  sample_t x_c   [TAPS+1];

  assign item_ch.ready = advance;
  assign accept        = item_ch.valid && advance;

  // Samples wait here for one less than the block delay. Tap loads pass
  // through the same stage so that they reach each cell in order with the
  // sample sums around them.
  fcf_delay_line u_delay (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .accept    (accept),
    .op        (item_ch.op),
    .sample_in (item_ch.sample_in),
    .tap_index (item_ch.tap_index),
    .tap_value (item_ch.tap_value),
    .tok       (tok_c[0]),
    .x_out     (x_c[0])
  );

  assign acc_c[0] = '0;

  // Cell k owns tap k and the sample that lags by the block delay plus k.
  // Each sample transaction adds one product per cell on its way along.
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    fcf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .cell_id (TAP_IDX_W'(k)),
      .tok_in  (tok_c[k]),
      .acc_in  (acc_c[k]),
      .x_in    (x_c[k]),
      .tok_out (tok_c[k+1]),
      .acc_out (acc_c[k+1]),
      .x_out   (x_c[k+1])
    );
  end

  // Scaling, saturation and the result register. The last history sample
  // shifted out of the chain is no longer needed.
  fcf_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .tok_in  (tok_c[TAPS]),
    .acc_in  (acc_c[TAPS]),
    .advance (advance),
    .result  (result_ch)
  );

  // A result only appears when a sample sum has left the last cell.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_ch.valid) |-> $past(tok_c[TAPS].valid && !tok_c[TAPS].is_load))
    else $error("result without a sample leaving the tap chain");

  // An empty result register never holds back the input side.
  assert property (@(posedge clk) disable iff (rst)
    !result_ch.valid |-> item_ch.ready)
    else $error("input stalled while the result register is empty");

  // Every accepted transaction enters the chain.
  assert property (@(posedge clk) disable iff (rst)
    (item_ch.valid && item_ch.ready) |=> tok_c[0].valid)
    else $error("accepted item missing at the head of the chain");

endmodule

`default_nettype wire

/* verif/tb.sv */
`default_nettype none

// Self-checking bench for the fast-convolution FIR filter core.
//
// The core behaves as a direct-form FIR filter with a fixed lag of
// BLOCK_DELAY samples. Each sample transaction produces exactly one filtered
// sample. A tap load produces nothing, and a load whose index is TAPS or more
// is dropped. This bench keeps its own copy of the coefficient bank and of the
// sample line, and it steps that copy at every accepted item transaction.
// Each sample transaction pushes the filtered value that it should produce
// onto a queue. The result monitor pops that queue in order and compares each
// sample_out value with it.
//
// The stimulus has two parts. A short table of directed rows comes first:
// full-scale samples, the first and last taps, out-of-range tap indexes, and
// junk in the unused fields. Every sample in that table is still inside the
// first BLOCK_DELAY samples after reset, so its output is known to be zero
// and is typed in. A random part follows. It is built from episodes, and each
// episode reloads the coefficients in some shape and then streams a burst of
// samples in some shape. Occasionally a stray load lands in the middle of a
// burst. The first two episodes drive full-scale taps and samples so that
// both saturation limits are reached.
//
// Flow control runs through phases, chosen from how many items have been
// taken so far: no idling at all, a sender that idles often, a receiver that
// stalls often, and light idling on both sides. Twice, the receiver also
// holds off for a long stretch while the sender keeps offering items. This
// fills the tap chain and forces the core to stall its input.
//
// Inputs are driven with nonblocking assignments at the rising edge. Each
// handshake is evaluated at the falling edge before the edge that completes
// it, so every decision reads settled values.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcf_pkg::*;

  // Past samples the filter can still reach: the lag plus the tap span.
  localparam int LINE_LEN     = TAPS + BLOCK_DELAY - 1;
  localparam int ITEM_TARGET  = 1050;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int PRINT_LIMIT  = 40;
  localparam int PHASE_ITEMS  = 200;

  // Shapes used when an episode reloads the coefficient bank.
  typedef enum int {
    COEF_MAX, COEF_MIN, COEF_RANDOM, COEF_SMALL, COEF_SPARSE
  } coef_shape_t;

  // Shapes used for the sample burst of an episode.
  typedef enum int {
    WAVE_POS_FULL, WAVE_NEG_FULL, WAVE_RANDOM, WAVE_TINY, WAVE_SQUARE
  } wave_shape_t;

  // One item transaction. When typed is set, typed_out is the known output.
  typedef struct packed {
    logic     op;
    sample_t  sample_in;
    tap_idx_t tap_index;
    coef_t    tap_value;
    logic     typed;
    sample_t  typed_out;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;

  fcf_item_if   item_ch ();
  fcf_result_if result_ch ();

  fast_convolution_fir_filter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .item_ch   (item_ch),
    .result_ch (result_ch)
  );

  // Local copy of the filter state.
  coef_t       coef_bank [TAPS]       = '{default: '0};
  sample_t     sample_line [LINE_LEN] = '{default: '0};
  int unsigned line_wr                = 0;

  // Filtered samples that are due, oldest first.
  sample_t expected_out [$];

  int unsigned mismatches     = 0;
  int unsigned items_taken    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_left      = 0;

  // Every sample in this table falls inside the first BLOCK_DELAY samples
  // after reset. The filter therefore sees only zero history, and each sample
  // row expects zero whatever the taps hold.
  stim_row_t directed_rows [16] = '{
    '{OP_SAMPLE, 16'sh7FFF, 7'd0,  16'sh0000, 1'b1, 16'sh0000},
    '{OP_SAMPLE, 16'sh8000, 7'd0,  16'sh0000, 1'b1, 16'sh0000},
    '{OP_SAMPLE, 16'sh0000, 7'd0,  16'sh0000, 1'b1, 16'sh0000},
    '{OP_LOAD,   16'sh0000, 7'd0,  16'sh7FFF, 1'b0, 16'sh0000},
    '{OP_LOAD,   16'sh0000, 7'd54, 16'sh8000, 1'b0, 16'sh0000},
    '{OP_LOAD,   16'sh1234, 7'd55, 16'sh7FFF, 1'b0, 16'sh0000},
    '{OP_LOAD,   16'shFFFF, 7'd64, 16'shFFFF, 1'b0, 16'sh0000},
    '{OP_SAMPLE, 16'sh0001, 7'd64, 16'sh7FFF, 1'b1, 16'sh0000},
    '{OP_LOAD,   16'sh7FFF, 7'd1,  16'shFFFF, 1'b0, 16'sh0000},
    '{OP_LOAD,   16'sh8000, 7'd8,  16'sh0001, 1'b0, 16'sh0000},
    '{OP_SAMPLE, 16'shFFFF, 7'd127, 16'sh8000, 1'b1, 16'sh0000},
    '{OP_SAMPLE, 16'sh5555, 7'd42, 16'shAAAA, 1'b1, 16'sh0000},
    '{OP_SAMPLE, 16'shAAAA, 7'd21, 16'sh5555, 1'b1, 16'sh0000},
    '{OP_LOAD,   16'sh0000, 7'd54, 16'sh4000, 1'b0, 16'sh0000},
    '{OP_SAMPLE, 16'sh8001, 7'd0,  16'sh0000, 1'b1, 16'sh0000},
    '{OP_SAMPLE, 16'sh7FFE, 7'd0,  16'sh0000, 1'b1, 16'sh0000}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run limit sits far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  // Steps the local filter copy by one item. The function returns 1 and the
  // filtered sample when the item is an audio sample.
  function automatic bit advance_filter(input stim_row_t row, output sample_t y);
    longint      acc;
    longint      quo;
    int unsigned pos;
    int          k;
    y = '0;
    if (row.op == OP_LOAD) begin
      if (row.tap_index < TAPS) begin
        coef_bank[row.tap_index] = row.tap_value;
      end
      return 1'b0;
    end
    acc = 0;
    for (k = 0; k < TAPS; k++) begin
      pos = (line_wr + LINE_LEN - (BLOCK_DELAY + k)) % LINE_LEN;
      acc += longint'(coef_bank[k]) * longint'(sample_line[pos]);
    end
    // Signed division truncates toward zero, which the core must match.
    quo = acc / (longint'(1) << FRAC_BITS);
    if (quo > 32767) begin
      quo = 32767;
    end else if (quo < -32768) begin
      quo = -32768;
    end
    y = sample_t'(quo);
    sample_line[line_wr] = row.sample_in;
    line_wr = (line_wr + 1) % LINE_LEN;
    return 1'b1;
  endfunction

  function automatic stim_row_t sample_row(input sample_t s);
    stim_row_t row;
    row.op        = OP_SAMPLE;
    row.sample_in = s;
    row.tap_index = tap_idx_t'($urandom);
    row.tap_value = coef_t'($urandom);
    row.typed     = 1'b0;
    row.typed_out = '0;
    return row;
  endfunction

  function automatic stim_row_t load_row(input int unsigned idx, input coef_t c);
    stim_row_t row;
    row.op        = OP_LOAD;
    row.sample_in = sample_t'($urandom);
    row.tap_index = tap_idx_t'(idx);
    row.tap_value = c;
    row.typed     = 1'b0;
    row.typed_out = '0;
    return row;
  endfunction

  // Offers one item and returns at the edge that accepts it. The task is
  // entered at a rising edge. Valid gets at most one assignment per step.
  task automatic drive_item(input stim_row_t row);
    sample_t y;
    case ((items_taken / PHASE_ITEMS) % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 58;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 58;
      end
      default: begin
        send_idle_pct  = 8;
        recv_stall_pct = 8;
      end
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.op        <= row.op;
    item_ch.sample_in <= row.sample_in;
    item_ch.tap_index <= row.tap_index;
    item_ch.tap_value <= row.tap_value;
    do @(negedge clk); while (!item_ch.ready);
    @(posedge clk);
    if (advance_filter(row, y)) begin
      expected_out.push_back(row.typed ? row.typed_out : y);
    end
    // A load that the core drops does not count as useful stimulus.
    if (!(row.op == OP_LOAD && row.tap_index >= TAPS)) begin
      items_taken++;
    end
  endtask

  // Reloads the coefficients in one shape, then streams a sample burst.
  task automatic run_episode(input coef_shape_t coef_shape, input wave_shape_t wave);
    int unsigned burst;
    int unsigned n;
    int          k;
    coef_t       c;
    sample_t     s;
    for (k = 0; k < TAPS; k++) begin
      // A random reload touches only about a quarter of the bank.
      if (coef_shape == COEF_RANDOM && $urandom_range(3) != 0) begin
        continue;
      end
      case (coef_shape)
        COEF_MAX:    c = 16'sh7FFF;
        COEF_MIN:    c = 16'sh8000;
        COEF_SMALL:  c = coef_t'(int'($urandom_range(512)) - 256);
        COEF_SPARSE: c = ($urandom_range(5) == 0) ? coef_t'($urandom) : '0;
        default:     c = coef_t'($urandom);
      endcase
      drive_item(load_row(k, c));
    end
    burst = $urandom_range(220, 140);
    for (n = 0; n < burst; n++) begin
      // The run stops streaming once enough items have been taken.
      if (items_taken >= ITEM_TARGET) begin
        break;
      end
      // The long hold-off is requested twice: once while the sender runs
      // flat out, and once later in the run.
      if (hold_requests < 2 && items_taken > 150 + 450 * hold_requests) begin
        hold_requests <= hold_requests + 1;
      end
      // A stray load sometimes breaks into the stream, and it may be out of
      // range.
      if ($urandom_range(19) == 0) begin
        drive_item(load_row($urandom_range(64), coef_t'($urandom)));
      end
      case (wave)
        WAVE_POS_FULL: s = 16'sh7FFF;
        WAVE_NEG_FULL: s = 16'sh8000;
        WAVE_TINY:     s = sample_t'(int'($urandom_range(6)) - 3);
        WAVE_SQUARE:   s = n[3] ? 16'sh7FFF : 16'sh8000;
        default:       s = sample_t'($urandom);
      endcase
      drive_item(sample_row(s));
    end
  endtask

  // Receiver: random stalls, except during a hold-off when ready stays low.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Runs the long receiver hold-off, counted in cycles, once per request.
  initial begin : holdoff_counter
    int unsigned served;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (hold_requests != served) begin
        hold_left <= HOLD_CYCLES;
        served++;
      end
    end
  end

  // Result monitor. A transaction that completes at the next rising edge is
  // already visible at the falling edge, so it is checked there.
  initial begin : result_monitor
    sample_t want;
    forever begin
      @(negedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("unexpected sample_out %0d", result_ch.sample_out));
        end else begin
          want = expected_out.pop_front();
          if (result_ch.sample_out !== want) begin
            report_mismatch($sformatf("sample_out %0d, expected %0d",
                                      result_ch.sample_out, want));
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned episode;
    int unsigned drain_cycles;
    item_ch.valid     <= 1'b0;
    item_ch.op        <= OP_SAMPLE;
    item_ch.sample_in <= '0;
    item_ch.tap_index <= '0;
    item_ch.tap_value <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      drive_item(directed_rows[r]);
    end

    // The first two episodes drive both saturation limits. The others are
    // drawn at random.
    episode = 0;
    while (items_taken < ITEM_TARGET) begin
      case (episode)
        0:       run_episode(COEF_MAX, WAVE_POS_FULL);
        1:       run_episode(COEF_MAX, WAVE_NEG_FULL);
        default: run_episode(coef_shape_t'($urandom_range(4)),
                             wave_shape_t'($urandom_range(4)));
      endcase
      episode++;
    end
    item_ch.valid <= 1'b0;

    // Drain, then give the tap chain its full latency to show any extra output.
    drain_cycles = 0;
    while (expected_out.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (TAPS + 8) @(posedge clk);
    if (expected_out.size() != 0) begin
      report_mismatch($sformatf("%0d filtered samples never came out",
                                expected_out.size()));
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
